// ----- design/mrle_pkg.sv -----
// Shared types and constants of the marker run-length block decoder.
// Used by mrle_ctrl, mrle_datapath and marker_rle_block_decoder_core; no dependencies.
`default_nettype none

package mrle_pkg;

    localparam int DEF_BLOCK_BYTES = 256;
    localparam int DEF_LANES       = 4;
    localparam int OUT_LANES       = 4;
    localparam int BYTE_W          = 8;
    localparam int LANE_CNT_W      = 3;
    localparam int TOTAL_W         = 9;

    typedef struct packed {
        logic accept;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic has_results;
        logic slot_free;
        logic last_load;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- design/mrle_ctrl.sv -----
// Controller of the marker run-length block decoder: accepts requests and sequences results.
// Depends on mrle_pkg for the command and status structs.
`default_nettype none

module mrle_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  mrle_pkg::t_dp_sts i_sts,
    output mrle_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   ready;

    always_comb begin
        ready        = (r_state == ST_IDLE) ||
                       (i_sts.slot_free && i_sts.last_load);
        o_cmd.load   = (r_state == ST_EMIT) && i_sts.slot_free;
        o_cmd.accept = i_in_valid && ready;
        o_in_stall   = !ready;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_sts.has_results) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_cmd.load && i_sts.last_load) begin
                    n_state = (o_cmd.accept && i_sts.has_results) ? ST_EMIT : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_only_on_final_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && r_state == ST_EMIT) |-> (o_cmd.load && i_sts.last_load))
        else $error("Request accepted while results of the previous one remain.");

    a_results_start_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.has_results) |=> (r_state == ST_EMIT))
        else $error("Request with results did not start emission.");

    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_sts.last_load && !o_cmd.accept) |=> (r_state == ST_IDLE))
        else $error("Controller did not return to idle after the final result.");

endmodule

`default_nettype wire

// ----- design/mrle_datapath.sv -----
// Datapath of the marker run-length block decoder: decode state, run counter, output register.
// Depends on mrle_pkg; driven by the command struct from mrle_ctrl.
`default_nettype none

module mrle_datapath #(
    parameter int BLOCK_BYTES = mrle_pkg::DEF_BLOCK_BYTES,
    parameter int LANES       = mrle_pkg::DEF_LANES
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_wr_en,
    input  wire  [mrle_pkg::BYTE_W-1:0]             i_cfg_wr_data,
    input  wire  [mrle_pkg::BYTE_W-1:0]             i_data_byte,
    input  wire                                     i_last_in,
    input  wire                                     i_out_stall,
    input  mrle_pkg::t_dp_cmd                       i_cmd,
    output mrle_pkg::t_dp_sts                       o_sts,
    output logic                                    o_out_valid,
    output logic [mrle_pkg::BYTE_W-1:0]             o_lane0,
    output logic [mrle_pkg::BYTE_W-1:0]             o_lane1,
    output logic [mrle_pkg::BYTE_W-1:0]             o_lane2,
    output logic [mrle_pkg::BYTE_W-1:0]             o_lane3,
    output logic [mrle_pkg::LANE_CNT_W-1:0]         o_lane_count,
    output logic                                    o_final_of_item,
    output logic                                    o_block_end,
    output logic                                    o_status,
    output logic [mrle_pkg::TOTAL_W-1:0]            o_byte_total
);

    localparam int EL = (LANES < 1) ? 1 : ((LANES > mrle_pkg::OUT_LANES) ?
                        mrle_pkg::OUT_LANES : LANES);
    localparam int PW = $clog2(BLOCK_BYTES + 1);
    localparam int CW = (PW > mrle_pkg::TOTAL_W) ? PW : mrle_pkg::TOTAL_W;
    localparam int BW = mrle_pkg::BYTE_W;
    localparam logic [BW-1:0] EL_B = BW'(EL);
    localparam logic [CW-1:0] BLOCK_C = CW'(BLOCK_BYTES);

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_COUNT,
        PH_VALUE
    } t_phase;

    t_phase                         r_phase;
    logic [BW-1:0]                  r_run_count;
    logic [PW-1:0]                  r_produced;
    logic                           r_full;
    logic [BW-1:0]                  r_marker;

    logic [BW-1:0]                  r_left;
    logic [BW-1:0]                  r_value;
    logic                           r_last;
    logic                           r_blk_status;
    logic [mrle_pkg::TOTAL_W-1:0]   r_blk_total;

    logic                           r_out_valid;
    logic [BW-1:0]                  r_lane [mrle_pkg::OUT_LANES];
    logic [mrle_pkg::LANE_CNT_W-1:0] r_lane_count;
    logic                           r_final;
    logic                           r_block_end;
    logic                           r_status;
    logic [mrle_pkg::TOTAL_W-1:0]   r_total;

    logic [CW-1:0]                  copies;
    logic [CW-1:0]                  remain;
    logic [CW-1:0]                  n_copies;
    logic [CW-1:0]                  remain_after;
    logic                           lit;
    logic [BW-1:0]                  n_emit;
    logic [CW-1:0]                  prod_new;
    logic [mrle_pkg::LANE_CNT_W-1:0] cnt;
    logic                           last_load;

    always_comb begin
        copies = '0;
        if (r_phase == PH_VALUE && r_run_count > 8'd1) begin
            copies = CW'(r_run_count - 8'd1);
        end
        remain       = BLOCK_C - CW'(r_produced);
        n_copies     = (copies < remain) ? copies : remain;
        remain_after = remain - n_copies;
        lit          = (remain_after != '0) && (i_data_byte != r_marker);
        if (r_full || r_phase == PH_COUNT) begin
            n_emit = '0;
        end else begin
            n_emit = BW'(n_copies + CW'(lit));
        end
        prod_new  = CW'(r_produced) + CW'(n_emit);
        cnt       = (r_left >= EL_B) ? mrle_pkg::LANE_CNT_W'(EL) :
                    mrle_pkg::LANE_CNT_W'(r_left);
        last_load = (r_left <= EL_B);
        o_sts.has_results = (n_emit != '0) || i_last_in;
        o_sts.slot_free   = !r_out_valid || !i_out_stall;
        o_sts.last_load   = last_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NORMAL;
            r_run_count <= '0;
            r_produced  <= '0;
            r_full      <= 1'b0;
            r_marker    <= '0;
            r_left      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_marker <= i_cfg_wr_data;
            end

            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.accept) begin
                r_left <= n_emit;
            end else if (i_cmd.load) begin
                r_left <= r_left - BW'(cnt);
            end

            if (i_cmd.accept) begin
                r_value <= i_data_byte;
                r_last  <= i_last_in;
                if (i_last_in) begin
                    r_blk_status <= (prod_new != BLOCK_C);
                    r_blk_total  <= prod_new[mrle_pkg::TOTAL_W-1:0];
                    r_phase      <= PH_NORMAL;
                    r_run_count  <= '0;
                    r_produced   <= '0;
                    r_full       <= 1'b0;
                end else if (!r_full) begin
                    if (r_phase == PH_COUNT) begin
                        r_run_count <= i_data_byte;
                        r_phase     <= PH_VALUE;
                    end else begin
                        r_run_count <= '0;
                        r_phase     <= ((remain_after != '0) && (i_data_byte == r_marker)) ?
                                       PH_COUNT : PH_NORMAL;
                    end
                    r_produced <= PW'(prod_new);
                    r_full     <= (prod_new == BLOCK_C);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int j = 0; j < mrle_pkg::OUT_LANES; j++) begin
                r_lane[j] <= (mrle_pkg::LANE_CNT_W'(j) < cnt) ? r_value : '0;
            end
            r_lane_count <= cnt;
            r_final      <= last_load;
            r_block_end  <= last_load && r_last;
            r_status     <= last_load && r_last && r_blk_status;
            r_total      <= (last_load && r_last) ? r_blk_total : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_lane0         = r_lane[0];
    assign o_lane1         = r_lane[1];
    assign o_lane2         = r_lane[2];
    assign o_lane3         = r_lane[3];
    assign o_lane_count    = r_lane_count;
    assign o_final_of_item = r_final;
    assign o_block_end     = r_block_end;
    assign o_status        = r_status;
    assign o_byte_total    = r_total;

    a_lane_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_lane_count <= mrle_pkg::LANE_CNT_W'(EL)))
        else $error("Result carries more lanes than configured.");

    a_block_end_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_block_end) |-> r_final)
        else $error("Block end on a result that is not the last of its request.");

    a_status_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_block_end) |-> (!r_status && r_total == '0))
        else $error("Status or total present without block end.");

    a_produced_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_produced) <= BLOCK_C) && (r_full == (CW'(r_produced) == BLOCK_C)))
        else $error("Produced byte count out of step with the full flag.");

endmodule

`default_nettype wire

// ----- design/marker_rle_block_decoder_core.sv -----
// Top level of the marker run-length block decoder: controller plus datapath.
// Depends on mrle_pkg, mrle_ctrl and mrle_datapath.
//
// Encoded bytes arrive one request at a time on the input channel (i_in_valid,
// o_in_stall, i_data_byte, i_last_in). Decoded bytes leave packed up to LANES per
// result on the output channel (o_out_valid, i_out_stall and the result fields).
// The marker byte is written through i_cfg_wr_en and i_cfg_wr_data; the user must
// write it while idle; the block does not enforce this. A request that decodes n
// bytes gives ceil(n / LANES) results, or one empty result when it ends a block
// and decodes nothing; marker and count bytes without the end flag give none.
// Results are loaded into the output register one per cycle while the receiver
// takes them. The next request is accepted in the cycle the final result of the
// current one is loaded, so literals sustain one request per cycle while the
// receiver takes them; a run occupies the result sequencer until its final result
// is loaded. A stalled result holds in the output register and backs up into
// o_in_stall. Reset clears the decode state, marker byte and output valid flag.
`default_nettype none

module marker_rle_block_decoder_core #(
    parameter int BLOCK_BYTES = mrle_pkg::DEF_BLOCK_BYTES,
    parameter int LANES       = mrle_pkg::DEF_LANES
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire  [mrle_pkg::BYTE_W-1:0]      i_cfg_wr_data,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [mrle_pkg::BYTE_W-1:0]      i_data_byte,
    input  wire                              i_last_in,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [mrle_pkg::BYTE_W-1:0]      o_lane0,
    output logic [mrle_pkg::BYTE_W-1:0]      o_lane1,
    output logic [mrle_pkg::BYTE_W-1:0]      o_lane2,
    output logic [mrle_pkg::BYTE_W-1:0]      o_lane3,
    output logic [mrle_pkg::LANE_CNT_W-1:0]  o_lane_count,
    output logic                             o_final_of_item,
    output logic                             o_block_end,
    output logic                             o_status,
    output logic [mrle_pkg::TOTAL_W-1:0]     o_byte_total
);

    mrle_pkg::t_dp_cmd cmd;
    mrle_pkg::t_dp_sts sts;

    mrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mrle_datapath #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .LANES       (LANES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_data_byte     (i_data_byte),
        .i_last_in       (i_last_in),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_lane0         (o_lane0),
        .o_lane1         (o_lane1),
        .o_lane2         (o_lane2),
        .o_lane3         (o_lane3),
        .o_lane_count    (o_lane_count),
        .o_final_of_item (o_final_of_item),
        .o_block_end     (o_block_end),
        .o_status        (o_status),
        .o_byte_total    (o_byte_total)
    );

endmodule

`default_nettype wire

// ----- dv/mrle_checker.sv -----
// Checker for the marker run-length block decoder: watches both channels, decodes each
// accepted request on its own copy of the state and compares every result field.
// Depends on mrle_pkg for the default block size and lane count.
module mrle_checker #(
    parameter int BLOCK_BYTES = mrle_pkg::DEF_BLOCK_BYTES,
    parameter int LANES       = mrle_pkg::DEF_LANES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  lane0,
    input  logic [7:0]  lane1,
    input  logic [7:0]  lane2,
    input  logic [7:0]  lane3,
    input  logic [2:0]  lane_count,
    input  logic        final_of_item,
    input  logic        block_end,
    input  logic        status,
    input  logic [8:0]  byte_total,
    output int          n_fail,
    output int          n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EFF_LANES = (LANES < 1) ? 1 : ((LANES > 4) ? 4 : LANES);

    typedef enum logic [1:0] {
        DEC_LITERAL = 2'd0,
        DEC_COUNT   = 2'd1,
        DEC_VALUE   = 2'd2
    } t_dec_phase;

    typedef struct packed {
        logic [3:0][7:0] lanes;
        logic [2:0]      count;
        logic            fin;
        logic            bend;
        logic            status;
        logic [8:0]      total;
    } t_word;

    t_word      words_q[$];
    logic [7:0] emitted[$];
    logic [7:0] marker;
    t_dec_phase phase;
    logic [7:0] run_len;
    int         produced;
    bit         full;

    initial begin
        n_fail    = 0;
        n_pending = 0;
    end

    function automatic void put_byte(logic [7:0] v);
        if (full) begin
            return;
        end
        emitted.push_back(v);
        produced++;
        if (produced >= BLOCK_BYTES) begin
            full = 1'b1;
        end
    endfunction

    function automatic void take_fresh(logic [7:0] v);
        if (full) begin
            phase = DEC_LITERAL;
        end else if (v == marker) begin
            phase = DEC_COUNT;
        end else begin
            put_byte(v);
            phase = DEC_LITERAL;
        end
    endfunction

    function automatic void decode_request(logic [7:0] v, logic last);
        int    copies;
        int    nres;
        t_word w;
        emitted.delete();
        if (!full) begin
            case (phase)
                DEC_COUNT: begin
                    run_len = v;
                    phase   = DEC_VALUE;
                end
                DEC_VALUE: begin
                    copies = (run_len > 1) ? run_len - 1 : 0;
                    while (copies > 0 && !full) begin
                        put_byte(v);
                        copies--;
                    end
                    run_len = '0;
                    take_fresh(v);
                end
                default: begin
                    take_fresh(v);
                end
            endcase
        end
        nres = (emitted.size() + EFF_LANES - 1) / EFF_LANES;
        if (nres == 0 && last) begin
            nres = 1;
        end
        for (int k = 0; k < nres; k++) begin
            w = '0;
            for (int j = 0; j < EFF_LANES; j++) begin
                if (emitted.size() > 0) begin
                    w.lanes[j] = emitted.pop_front();
                    w.count    = w.count + 3'd1;
                end
            end
            w.fin = (k == nres - 1);
            if (w.fin && last) begin
                w.bend   = 1'b1;
                w.status = (produced != BLOCK_BYTES);
                w.total  = produced[8:0];
            end
            words_q.push_back(w);
        end
        if (last) begin
            phase    = DEC_LITERAL;
            run_len  = '0;
            produced = 0;
            full     = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            n_fail++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk) begin
        t_word want;
        t_word got;
        if (!rst_n) begin
            marker   = '0;
            phase    = DEC_LITERAL;
            run_len  = '0;
            produced = 0;
            full     = 1'b0;
            words_q.delete();
        end else begin
            if (out_valid && !out_stall) begin
                got = {{lane3, lane2, lane1, lane0}, lane_count, final_of_item, block_end,
                       status, byte_total};
                if (words_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: result expected none actual lane_count %0d block_end %0d",
                             $time, got.count, got.bend);
                end else begin
                    want = words_q.pop_front();
                    for (int j = 0; j < 4; j++) begin
                        check_field($sformatf("lane%0d", j), want.lanes[j], got.lanes[j]);
                    end
                    check_field("lane_count", want.count, got.count);
                    check_field("final_of_item", want.fin, got.fin);
                    check_field("block_end", want.bend, got.bend);
                    check_field("status", want.status, got.status);
                    check_field("byte_total", want.total, got.total);
                end
            end
            if (cfg_wr_en) begin
                marker = cfg_wr_data;
            end
            if (in_valid && !in_stall) begin
                decode_request(data_byte, last_in);
            end
        end
        n_pending = words_q.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for marker_rle_block_decoder_core: drives directed and random encoded
// blocks under several marker values and idle patterns, and gives the verdict.
// Depends on mrle_pkg, the decoder core and mrle_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int PHASE_ITEMS   = 34;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_data_byte   = 8'h00;
    logic       i_last_in     = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_lane0;
    logic [7:0] o_lane1;
    logic [7:0] o_lane2;
    logic [7:0] o_lane3;
    logic [2:0] o_lane_count;
    logic       o_final_of_item;
    logic       o_block_end;
    logic       o_status;
    logic [8:0] o_byte_total;

    int         n_fail;
    int         n_pending;
    int         send_idle_pct  = 0;
    int         stall_idle_pct = 0;
    int         idle_cycles    = 0;
    int         items_sent     = 0;
    logic [7:0] cur_marker     = 8'h00;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    marker_rle_block_decoder_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_in       (i_last_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_lane0         (o_lane0),
        .o_lane1         (o_lane1),
        .o_lane2         (o_lane2),
        .o_lane3         (o_lane3),
        .o_lane_count    (o_lane_count),
        .o_final_of_item (o_final_of_item),
        .o_block_end     (o_block_end),
        .o_status        (o_status),
        .o_byte_total    (o_byte_total)
    );

    mrle_checker u_checker (
        .clk           (i_clk),
        .rst_n         (i_rst_n),
        .cfg_wr_en     (i_cfg_wr_en),
        .cfg_wr_data   (i_cfg_wr_data),
        .in_valid      (i_in_valid),
        .in_stall      (o_in_stall),
        .data_byte     (i_data_byte),
        .last_in       (i_last_in),
        .out_valid     (o_out_valid),
        .out_stall     (i_out_stall),
        .lane0         (o_lane0),
        .lane1         (o_lane1),
        .lane2         (o_lane2),
        .lane3         (o_lane3),
        .lane_count    (o_lane_count),
        .final_of_item (o_final_of_item),
        .block_end     (o_block_end),
        .status        (o_status),
        .byte_total    (o_byte_total),
        .n_fail        (n_fail),
        .n_pending     (n_pending)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_MAX) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_in   <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (n_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_marker(logic [7:0] v, int send_pct, int stall_pct);
        wait_drained();
        send_idle_pct  = send_pct;
        stall_idle_pct = stall_pct;
        cur_marker     = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_literal();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == cur_marker) begin
            b = b ^ 8'h01;
        end
        return b;
    endfunction

    task automatic send_block();
        int         n_tokens;
        int         kind;
        bit         last;
        logic [7:0] count;
        n_tokens = $urandom_range(2, 10);
        for (int t = 0; t < n_tokens; t++) begin
            last = (t == n_tokens - 1);
            kind = $urandom_range(99);
            if (last && $urandom_range(9) == 0) begin
                send_byte(cur_marker, 1'($urandom_range(1)));
                if (!i_last_in) begin
                    send_byte(8'($urandom_range(255)), 1'b1);
                end
            end else if (kind < 45) begin
                send_byte(pick_literal(), last);
            end else if (kind < 88) begin
                count = ($urandom_range(9) < 7) ? 8'($urandom_range(8)) :
                                                  8'($urandom_range(255));
                send_byte(cur_marker, 1'b0);
                send_byte(count, 1'b0);
                send_byte(8'($urandom_range(255)), last);
            end else begin
                send_byte(8'($urandom_range(255)), last);
            end
        end
    endtask

    task automatic run_random(logic [7:0] v, int send_pct, int stall_pct);
        int start;
        load_marker(v, send_pct, stall_pct);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            send_block();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_marker(8'hFF, 0, 0);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h77, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h04, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b1);

        run_random(8'h00, 0, 0);
        run_random(8'hFF, 57, 0);
        run_random(8'($urandom_range(255)), 0, 57);
        run_random(8'($urandom_range(255)), 18, 18);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
